// ===== hdl/ir_remote_multitap_decoder_top_assert.svh =====
// Assertion macros shared by the IR remote multi-tap decoder modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef IR_REMOTE_MULTITAP_DECODER_TOP_ASSERT_SVH
`define IR_REMOTE_MULTITAP_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IRMT_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define IRMT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IRMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IRMT_ASSERT(label, expr)
`define IRMT_ASSERT_IMPL(label, ante, cons)
`define IRMT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/irmt_pkg.sv =====
// Package for the IR remote multi-tap decoder: constants, command and
// status structs, and the multi-tap character tables. No dependencies.
package irmt_pkg;

    localparam int SAMPLES_DEF = 84;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int TIME_W      = 32;
    localparam int DIVIDEND_W  = 34;
    localparam int DIVISOR_W   = 25;
    localparam int DIV_STEPS   = DIVIDEND_W;

    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 24'd22550;
    localparam logic [CFG_W-1:0] FRAME_WINDOW_RST  = 24'd2000000;
    localparam logic [15:0]      CHARX             = 16'd6;
    localparam logic [3:0]       NO_KEY            = 4'hF;

    // Input opcodes.
    localparam logic OP_EDGE       = 1'b0;
    localparam logic OP_TIME_CHECK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_PERIOD = 2'd0,
        CFG_FRAME_WINDOW  = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic load_item;
        logic start_frame;
        logic div_start;
        logic div_step;
        logic fill;
        logic decode;
    } irmt_cmd_t;

    typedef struct packed {
        logic expired;
        logic is_edge;
        logic started;
    } irmt_status_t;

    // Number of characters behind a key; key 1 and codes above 9 have none.
    function automatic logic [2:0] set_len(input logic [3:0] key);
        logic [2:0] len;
        unique case (key)
            4'd0:                         len = 3'd1;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
            4'd8:                         len = 3'd3;
            4'd7, 4'd9:                   len = 3'd4;
            default:                      len = 3'd0;
        endcase
        return len;
    endfunction

    // First character of a key's set; the others follow in ASCII order.
    function automatic logic [7:0] char_base(input logic [3:0] key);
        logic [7:0] c;
        unique case (key)
            4'd0:    c = " ";
            4'd2:    c = "a";
            4'd3:    c = "d";
            4'd4:    c = "g";
            4'd5:    c = "j";
            4'd6:    c = "m";
            4'd7:    c = "p";
            4'd8:    c = "t";
            4'd9:    c = "w";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/irmt_datapath.sv =====
// Datapath of the IR remote multi-tap decoder: configuration, frame state,
// serial divider, sample register, key decode and text state. Uses irmt_pkg.
`include "ir_remote_multitap_decoder_top_assert.svh"

module irmt_datapath #(
    parameter int SAMPLES = irmt_pkg::SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  irmt_pkg::irmt_cmd_t             cmd,
    output irmt_pkg::irmt_status_t          status,
    input  logic                            cfg_valid,
    input  logic [irmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irmt_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            opcode,
    input  logic [irmt_pkg::TIME_W-1:0]     time_now,
    output logic signed [4:0]               key_value,
    output logic                            key_accepted,
    output logic [7:0]                      shown_char,
    output logic                            commit_valid,
    output logic [7:0]                      commit_char,
    output logic [15:0]                     cursor_x
);
    import irmt_pkg::*;

    localparam int CNT_W    = $clog2(SAMPLES + 1);
    localparam int DEC_BASE = 2 * (SAMPLES / 2) - 8;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(SAMPLES);

    logic [CFG_W-1:0]      sample_period_reg;
    logic [CFG_W-1:0]      frame_window_reg;
    logic                  opcode_reg;
    logic [TIME_W-1:0]     time_reg;
    logic                  frame_started_reg;
    logic [TIME_W-1:0]     frame_start_reg;
    logic [TIME_W-1:0]     last_edge_reg;
    logic                  parity_reg;
    logic [SAMPLES-1:0]    sample_bits_reg;
    logic [SAMPLES-1:0]    sample_bits_next;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [3:0]            prev_key_reg;
    logic [1:0]            tap_reg;
    logic [7:0]            cur_char_reg;
    logic [15:0]           cursor_reg;
    logic [DIVISOR_W-1:0]  div_rem_reg;
    logic [DIVISOR_W-1:0]  div_rem_next;
    logic [DIVIDEND_W-1:0] div_quo_reg;
    logic [DIVIDEND_W-1:0] div_quo_next;
    logic [4:0]            key_reg;
    logic                  accepted_reg;
    logic [7:0]            shown_reg;
    logic                  commit_reg;
    logic [7:0]            commit_char_reg;
    logic [15:0]           cursor_out_reg;

    logic [CFG_W-1:0]      period_eff;
    logic [DIVISOR_W-1:0]  divisor;
    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W-1:0]     interval;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W:0]    rem_shift;
    logic                  take;
    logic [CNT_W-1:0]      n_clamp;
    logic [CNT_W:0]        end_sum;
    logic [CNT_W-1:0]      end_cnt;
    logic [1:0]            sym [4];
    logic [4:0]            key_calc;
    logic [3:0]            k4;
    logic                  accepted;
    logic [2:0]            tap_inc;
    logic [1:0]            tap_new;
    logic                  commit;
    logic [15:0]           cursor_new;
    logic [7:0]            char_new;
    logic                  stale;

    assign period_eff = (sample_period_reg == '0) ? CFG_W'(1) : sample_period_reg;
    assign divisor    = {period_eff, 1'b0};
    assign elapsed    = time_reg - frame_start_reg;
    assign interval   = time_reg - last_edge_reg;
    // Rounding quotient: (2 * interval + p) / (2 * p).
    assign dividend   = {1'b0, interval, 1'b0} + {{(DIVIDEND_W - CFG_W){1'b0}}, period_eff};

    assign status.expired = frame_started_reg
                            && (elapsed > {{(TIME_W - CFG_W){1'b0}}, frame_window_reg});
    assign status.is_edge = (opcode_reg == OP_EDGE);
    assign status.started = frame_started_reg;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_shift    = {div_rem_reg, div_quo_reg[DIVIDEND_W-1]};
        take         = rem_shift >= {1'b0, divisor};
        div_rem_next = take ? DIVISOR_W'(rem_shift - {1'b0, divisor})
                            : rem_shift[DIVISOR_W-1:0];
        div_quo_next = {div_quo_reg[DIVIDEND_W-2:0], take};
    end

    // Sample count is clamped early so only narrow values reach the fill logic.
    always_comb
    begin
        n_clamp = (div_quo_reg > DIVIDEND_W'(SAMPLES)) ? FULL : div_quo_reg[CNT_W-1:0];
        end_sum = {1'b0, fill_reg} + {1'b0, n_clamp};
        end_cnt = (end_sum > (CNT_W + 1)'(SAMPLES)) ? FULL : end_sum[CNT_W-1:0];
        fill_next = end_cnt;
        sample_bits_next = sample_bits_reg;
        for (int i = 0; i < SAMPLES; i++)
        begin
            if ((CNT_W'(i) >= fill_reg) && (CNT_W'(i) < end_cnt))
            begin
                sample_bits_next[i] = parity_reg;
            end
        end
    end

    // Manchester pairs: (0,1) is +1, (1,0) is 0, anything else is -1.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            unique case ({sample_bits_reg[DEC_BASE + 2 * j], sample_bits_reg[DEC_BASE + 2 * j + 1]})
                2'b01:   sym[j] = 2'b01;
                2'b10:   sym[j] = 2'b00;
                default: sym[j] = 2'b11;
            endcase
        end
        key_calc = ({{3{sym[0][1]}}, sym[0]} << 3) + ({{3{sym[1][1]}}, sym[1]} << 2)
                 + ({{3{sym[2][1]}}, sym[2]} << 1) + {{3{sym[3][1]}}, sym[3]};
    end

    assign k4       = key_calc[3:0];
    assign accepted = (key_calc == 5'd0) || ((key_calc >= 5'd2) && (key_calc <= 5'd9));
    assign tap_inc  = {1'b0, tap_reg} + 3'd1;

    always_comb
    begin
        commit     = 1'b0;
        cursor_new = cursor_reg;
        tap_new    = 2'd0;
        if (prev_key_reg == NO_KEY)
        begin
            tap_new = 2'd0;
        end
        else if (prev_key_reg == k4)
        begin
            tap_new = (tap_inc >= set_len(k4)) ? 2'd0 : tap_inc[1:0];
        end
        else
        begin
            commit     = 1'b1;
            cursor_new = cursor_reg + CHARX;
        end
        char_new = char_base(k4) + {6'd0, tap_new};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= SAMPLE_PERIOD_RST;
            frame_window_reg  <= FRAME_WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SAMPLE_PERIOD)
            begin
                sample_period_reg <= cfg_data;
            end
            else if (cfg_index == CFG_FRAME_WINDOW)
            begin
                frame_window_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_started_reg <= 1'b0;
            frame_start_reg   <= '0;
            last_edge_reg     <= '0;
            parity_reg        <= 1'b0;
            sample_bits_reg   <= '0;
            fill_reg          <= '0;
            prev_key_reg      <= NO_KEY;
            tap_reg           <= 2'd0;
            cur_char_reg      <= 8'd0;
            cursor_reg        <= 16'd0;
        end
        else
        begin
            priority if (cmd.decode)
            begin
                frame_started_reg <= 1'b0;
                frame_start_reg   <= '0;
                last_edge_reg     <= '0;
                parity_reg        <= 1'b0;
                sample_bits_reg   <= '0;
                fill_reg          <= '0;
                if (accepted)
                begin
                    prev_key_reg <= k4;
                    tap_reg      <= tap_new;
                    cur_char_reg <= char_new;
                    cursor_reg   <= cursor_new;
                end
            end
            else if (cmd.start_frame)
            begin
                frame_started_reg <= 1'b1;
                frame_start_reg   <= time_reg;
                last_edge_reg     <= time_reg;
                parity_reg        <= 1'b0;
            end
            else if (cmd.fill)
            begin
                sample_bits_reg <= sample_bits_next;
                fill_reg        <= fill_next;
                parity_reg      <= !parity_reg;
                last_edge_reg   <= time_reg;
            end
            else
            begin
                fill_reg <= fill_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            opcode_reg <= opcode;
            time_reg   <= time_now;
        end
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= dividend;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
        end
        if (cmd.decode)
        begin
            key_reg         <= key_calc;
            accepted_reg    <= accepted;
            shown_reg       <= accepted ? char_new : cur_char_reg;
            commit_reg      <= accepted && commit;
            commit_char_reg <= (accepted && commit) ? cur_char_reg : 8'd0;
            cursor_out_reg  <= accepted ? cursor_new : cursor_reg;
        end
    end

    assign key_value    = $signed(key_reg);
    assign key_accepted = accepted_reg;
    assign shown_char   = shown_reg;
    assign commit_valid = commit_reg;
    assign commit_char  = commit_char_reg;
    assign cursor_x     = cursor_out_reg;

    // Samples at or above the fill count must still be clear.
    always_comb
    begin
        stale = 1'b0;
        for (int i = 0; i < SAMPLES; i++)
        begin
            if ((CNT_W'(i) >= fill_reg) && sample_bits_reg[i])
            begin
                stale = 1'b1;
            end
        end
    end

    `IRMT_ASSERT(a_fill_in_range, fill_reg <= FULL)
    `IRMT_ASSERT(a_no_stale_samples, !stale)
    `IRMT_ASSERT_NEXT(a_decode_clears, cmd.decode, (fill_reg == '0) && !frame_started_reg)

endmodule

// ===== hdl/irmt_ctrl.sv =====
// Controller of the IR remote multi-tap decoder: sequences the check,
// divide, fill and decode steps and owns the result valid. Uses irmt_pkg.
`include "ir_remote_multitap_decoder_top_assert.svh"

module irmt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output irmt_pkg::irmt_cmd_t    cmd,
    input  irmt_pkg::irmt_status_t status
);
    import irmt_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_FILL  = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0] div_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    // The result register can take a new beat when empty or draining now.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.expired)
                begin
                    if (slot_free)
                    begin
                        cmd.decode = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (status.is_edge && !status.started)
                begin
                    cmd.start_frame = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (status.is_edge)
                begin
                    cmd.div_start = 1'b1;
                    div_cnt_next  = '0;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + CNT_W'(1);
                end
            end
            ST_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.decode)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `IRMT_ASSERT_IMPL(a_decode_has_slot, cmd.decode, !out_valid_reg || out_ready)
    `IRMT_ASSERT_IMPL(a_fill_after_div, cmd.fill, $past(state_reg) == ST_DIV)
    `IRMT_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, state_reg == ST_CHECK)

endmodule

// ===== hdl/ir_remote_multitap_decoder_top.sv =====
// Top level of the IR remote multi-tap decoder: joins the controller and
// the datapath. Uses irmt_pkg, irmt_ctrl and irmt_datapath.

// Takes one item at a time. A time check, or the first edge of a frame,
// goes through accept and the expiry check. A frame that has expired goes
// through both, plus any wait for the result register to empty, and returns
// one beat. A later edge goes through accept, check, the restoring divider
// that rounds the interval to a sample count (one quotient bit per cycle),
// and a final step to write the samples. A beat waiting on the result port
// does not hold off new items unless one of them closes another frame. The
// configuration port is always ready.
module ir_remote_multitap_decoder_top #(
    parameter int SAMPLES = irmt_pkg::SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irmt_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [irmt_pkg::TIME_W-1:0]     time_now,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [4:0]               key_value,
    output logic                            key_accepted,
    output logic [7:0]                      shown_char,
    output logic                            commit_valid,
    output logic [7:0]                      commit_char,
    output logic [15:0]                     cursor_x
);
    import irmt_pkg::*;

    irmt_cmd_t    cmd;
    irmt_status_t status;

    assign cfg_ready = 1'b1;

    irmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    irmt_datapath #(
        .SAMPLES (SAMPLES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .time_now     (time_now),
        .key_value    (key_value),
        .key_accepted (key_accepted),
        .shown_char   (shown_char),
        .commit_valid (commit_valid),
        .commit_char  (commit_char),
        .cursor_x     (cursor_x)
    );

endmodule

// ===== tb/tb_ir_remote_multitap_decoder_top.sv =====
// Self-checking testbench for ir_remote_multitap_decoder_top: builds IR frames
// from chosen line-code samples and checks every decoded key beat against a
// behavioral predictor. Depends on irmt_pkg and the RTL under hdl/.
module tb_ir_remote_multitap_decoder_top;

    import irmt_pkg::*;

    localparam int NSAMP      = SAMPLES_DEF;
    localparam int STALL_MAX  = 3000;
    localparam int SETTLE     = 60;

    typedef int unsigned run_q_t[$];

    typedef struct {
        logic signed [4:0] key;
        logic              accepted;
        logic [7:0]        shown;
        logic              commit;
        logic [7:0]        committed;
        logic [15:0]       column;
    } keypress_t;

    class multitap_scoreboard;
        bit [23:0]      period_reg;
        bit [23:0]      window_reg;
        bit             started;
        bit [31:0]      start_t;
        bit [31:0]      last_t;
        bit             parity;
        bit [NSAMP-1:0] samples;
        int             fill;
        bit [3:0]       prev_key;
        int             tap;
        bit [7:0]       cur_char;
        bit [15:0]      column;
        string          letters[10];
        keypress_t      pending_keys[$];
        int             frames_predicted;
        int             errors;

        function new();
            letters = '{" ", "", "abc", "def", "ghi", "jkl", "mno", "pqrs", "tuv", "wxyz"};
            period_reg = SAMPLE_PERIOD_RST;
            window_reg = FRAME_WINDOW_RST;
            prev_key = NO_KEY;
            tap = 0;
            cur_char = 8'd0;
            column = 16'd0;
            frames_predicted = 0;
            errors = 0;
            clear_frame();
        endfunction

        function void set_reg(cfg_index_t idx, bit [23:0] value);
            case (idx)
                CFG_SAMPLE_PERIOD: period_reg = value;
                CFG_FRAME_WINDOW:  window_reg = value;
                default: ;
            endcase
        endfunction

        function void clear_frame();
            started = 1'b0;
            start_t = '0;
            last_t = '0;
            parity = 1'b0;
            samples = '0;
            fill = 0;
        endfunction

        function int pair_symbol(int pair);
            bit a;
            bit b;
            a = samples[2 * pair];
            b = samples[2 * pair + 1];
            if (!a && b)
                return 1;
            if (a && !b)
                return 0;
            return -1;
        endfunction

        function void add_edge(bit [31:0] t);
            bit [31:0]       diff;
            longint unsigned span;
            longint unsigned per;
            longint unsigned count;
            if (!started) begin
                started = 1'b1;
                start_t = t;
                last_t = t;
                parity = 1'b0;
                return;
            end
            // The interval wraps at 32 bits before it is widened.
            diff = t - last_t;
            span = diff;
            per = (period_reg == 0) ? 1 : period_reg;
            count = (2 * span + per) / (2 * per);
            while (count > 0 && fill < NSAMP) begin
                samples[fill] = parity;
                fill++;
                count--;
            end
            parity = ~parity;
            last_t = t;
        endfunction

        // Applies one accepted input beat and queues the key beat it closes, if any.
        function void absorb_item(bit op, bit [31:0] t);
            bit [31:0] elapsed;
            int        key;
            int        next_tap;
            bit [3:0]  k;
            keypress_t r;
            elapsed = t - start_t;
            if (started && elapsed > {8'd0, window_reg}) begin
                key = 8 * pair_symbol(NSAMP / 2 - 4) + 4 * pair_symbol(NSAMP / 2 - 3)
                    + 2 * pair_symbol(NSAMP / 2 - 2) + pair_symbol(NSAMP / 2 - 1);
                r.key = key[4:0];
                r.accepted = (key == 0) || (key >= 2 && key <= 9);
                r.commit = 1'b0;
                r.committed = 8'd0;
                if (r.accepted) begin
                    k = key[3:0];
                    if (prev_key == NO_KEY) begin
                        tap = 0;
                    end
                    else if (prev_key == k) begin
                        next_tap = tap + 1;
                        tap = (next_tap >= letters[k].len()) ? 0 : next_tap;
                    end
                    else begin
                        r.commit = 1'b1;
                        r.committed = cur_char;
                        column = column + CHARX;
                        tap = 0;
                    end
                    prev_key = k;
                    cur_char = letters[k][tap];
                end
                r.shown = cur_char;
                r.column = column;
                pending_keys.push_back(r);
                frames_predicted++;
                // The receiver is deaf during decode, so an edge here is dropped.
                clear_frame();
                return;
            end
            if (op == OP_EDGE)
                add_edge(t);
        endfunction

        function bit field_ok(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, exp_v, act_v);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_keypress(keypress_t got);
            keypress_t want;
            bit        ok;
            if (pending_keys.size() == 0) begin
                errors++;
                $display("%0t: key beat with no frame pending, expected none, got key %0d",
                         $time, got.key);
                return;
            end
            want = pending_keys.pop_front();
            ok = field_ok("key_value", {11'd0, want.key}, {11'd0, got.key});
            ok &= field_ok("key_accepted", {15'd0, want.accepted}, {15'd0, got.accepted});
            ok &= field_ok("shown_char", {8'd0, want.shown}, {8'd0, got.shown});
            ok &= field_ok("commit_valid", {15'd0, want.commit}, {15'd0, got.commit});
            ok &= field_ok("commit_char", {8'd0, want.committed}, {8'd0, got.committed});
            ok &= field_ok("cursor_x", want.column, got.column);
            if (!ok)
                errors++;
        endfunction

        function int pending();
            return pending_keys.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = CFG_SAMPLE_PERIOD;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic               opcode    = OP_EDGE;
    logic [TIME_W-1:0]  time_now  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [4:0]  key_value;
    logic               key_accepted;
    logic [7:0]         shown_char;
    logic               commit_valid;
    logic [7:0]         commit_char;
    logic [15:0]        cursor_x;

    multitap_scoreboard sb;
    int unsigned        gen_period    = SAMPLE_PERIOD_RST;
    int unsigned        gen_window    = FRAME_WINDOW_RST;
    int                 in_idle_pct   = 0;
    int                 out_stall_pct = 0;
    int                 items_sent    = 0;
    int                 gen_last_key  = 2;

    ir_remote_multitap_decoder_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .time_now     (time_now),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .key_value    (key_value),
        .key_accepted (key_accepted),
        .shown_char   (shown_char),
        .commit_valid (commit_valid),
        .commit_char  (commit_char),
        .cursor_x     (cursor_x)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Key beats are checked with the values seen at the edge that moves them.
    always @(posedge clk)
    begin
        keypress_t got;
        if (rst_n && out_valid && out_ready) begin
            got.key = key_value;
            got.accepted = key_accepted;
            got.shown = shown_char;
            got.commit = commit_valid;
            got.committed = commit_char;
            got.column = cursor_x;
            sb.check_keypress(got);
        end
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_MAX) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_ir_remote_multitap_decoder_top: done, errors");
        $finish;
    end

    // Valid stays high across back-to-back beats; it drops only while idling.
    task automatic send_item(input bit op, input logic [31:0] t);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        time_now <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.absorb_item(op, t);
        items_sent++;
    endtask

    task automatic set_regs(input int unsigned per, input int unsigned win);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SAMPLE_PERIOD;
        cfg_data <= per[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(CFG_SAMPLE_PERIOD, per[CFG_W-1:0]);
        cfg_index <= CFG_FRAME_WINDOW;
        cfg_data <= win[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(CFG_FRAME_WINDOW, win[CFG_W-1:0]);
        cfg_valid <= 1'b0;
        gen_period = per;
        gen_window = win;
    endtask

    task automatic quiesce();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Run lengths alternate in level starting at 0; a zero run only flips the level.
    function automatic run_q_t runs_of(input bit [NSAMP-1:0] s, input int count);
        run_q_t      runs;
        bit          level;
        int unsigned len;
        level = 1'b0;
        len = 0;
        for (int i = 0; i < count; i++) begin
            if (s[i] != level) begin
                runs.push_back(len);
                level = ~level;
                len = 0;
            end
            len++;
        end
        runs.push_back(len);
        return runs;
    endfunction

    task automatic send_runs(input logic [31:0] t0, input run_q_t runs, input bit close_edge);
        logic [31:0] t;
        longint      step;
        t = t0;
        send_item(OP_EDGE, t0);
        foreach (runs[i]) begin
            if (runs[i] == 0)
                step = $urandom_range(0, gen_period / 4);
            else
                step = longint'(runs[i]) * gen_period
                     + longint'($urandom_range(0, gen_period - 1)) - longint'(gen_period / 2);
            t = t + step[31:0];
            send_item(OP_EDGE, t);
            if ($urandom_range(0, 19) == 0)
                send_item(OP_TIME_CHECK, t);
        end
        t = t0 + gen_window + 32'd1 + $urandom_range(0, gen_period);
        send_item(close_edge ? OP_EDGE : OP_TIME_CHECK, t);
    endtask

    task automatic random_frame();
        bit [NSAMP-1:0] s;
        run_q_t         runs;
        int             k;
        int             shape;
        int             count;
        for (int i = 0; i < NSAMP; i++)
            s[i] = 1'($urandom_range(0, 1));
        // Most frames carry a clean key code; the rest keep random tail samples.
        if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 9) < 4) begin
                k = gen_last_key;
            end
            else begin
                k = $urandom_range(1, 9);
                if (k == 1)
                    k = 0;
            end
            gen_last_key = k;
            for (int j = 0; j < 4; j++) begin
                s[NSAMP - 8 + 2 * j] = ~k[3 - j];
                s[NSAMP - 7 + 2 * j] = k[3 - j];
            end
        end
        shape = $urandom_range(0, 9);
        count = (shape == 7) ? $urandom_range(0, NSAMP - 1) : NSAMP;
        runs = runs_of(s, count);
        if (shape == 8)
            runs[runs.size() - 1] += $urandom_range(1, 20);
        send_runs($urandom, runs, $urandom_range(0, 3) == 0);
    endtask

    task automatic random_items(input int goal_items, input int goal_keys);
        int items0;
        int keys0;
        items0 = items_sent;
        keys0 = sb.frames_predicted;
        while (items_sent - items0 < goal_items || sb.frames_predicted - keys0 < goal_keys) begin
            if ($urandom_range(0, 99) < 85) begin
                random_frame();
            end
            else begin
                repeat ($urandom_range(1, 6))
                    send_item($urandom_range(0, 1) ? OP_TIME_CHECK : OP_EDGE, $urandom);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned per, input int unsigned win,
                             input int send_pct, input int recv_pct);
        in_idle_pct = send_pct;
        out_stall_pct = recv_pct;
        set_regs(per, win);
        random_items(280, 6);
        quiesce();
    endtask

    initial
    begin
        run_q_t runs;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A time check with no frame open does nothing.
        send_item(OP_TIME_CHECK, 32'h0000_0000);
        // Short frame whose times wrap past zero; unfilled samples decode as invalid.
        send_item(OP_EDGE, 32'hFFFF_FFFF);
        send_item(OP_EDGE, 32'hFFFF_FFFF + 3 * gen_period);
        send_item(OP_TIME_CHECK, 32'hFFFF_FFFF + gen_window + 1);
        // An edge that closes a frame is dropped rather than starting a new one.
        send_item(OP_EDGE, 32'h0000_0000);
        send_item(OP_EDGE, gen_window + 1);
        // Full frame whose last four pairs all decode as one: key 15, rejected.
        runs = '{77, 1, 1, 1, 1, 1, 1, 1};
        send_runs(32'h8000_0000, runs, 1'b0);
        // Key 0 with extra samples past the end of the register.
        runs = '{76, 1, 1, 1, 1, 1, 1, 1, 6};
        send_runs(32'h7FFF_FFF0, runs, 1'b0);

        random_items(280, 6);
        quiesce();

        run_phase(1, 150, 87, 0);
        run_phase(24'hFF_FFFF, 24'hFF_FFFF, 0, 87);
        run_phase(4000, 1, 9, 9);
        run_phase(180000, 24'hFF_FFFF, 0, 87);
        run_phase(SAMPLE_PERIOD_RST, FRAME_WINDOW_RST, 87, 0);

        if (sb.errors == 0)
            $display("tb_ir_remote_multitap_decoder_top: done, clean");
        else
            $display("tb_ir_remote_multitap_decoder_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/irmt_pkg.sv
hdl/irmt_datapath.sv
hdl/irmt_ctrl.sv
hdl/ir_remote_multitap_decoder_top.sv
tb/tb_ir_remote_multitap_decoder_top.sv
